[hdl/sbrd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrd_pkg
// shared widths, constants and transaction types of the bear regime detector
// ----------------------------------------------------------------------------
package sbrd_pkg;

    localparam int WINDOW      = 200;
    localparam int SLOT_W      = $clog2(WINDOW);
    localparam int SEEN_W      = $clog2(WINDOW + 1);

    localparam int TIME_W      = 44;
    localparam int PRICE_W     = 32;
    localparam int SUM_W       = 40;
    localparam int RUN_W       = 16;
    localparam int NEED_W      = 10;

    localparam logic [NEED_W-1:0] NEED_RESET = 10'd20;
    localparam logic [RUN_W-1:0]  RUN_MAX    = {RUN_W{1'b1}};

    localparam longint MS_PER_DAY  = 86400 * 1000;
    localparam int     MS_SHIFT    = 10;
    localparam int     REM_W       = TIME_W - MS_SHIFT;
    localparam longint DAY_DIV     = MS_PER_DAY >> MS_SHIFT;
    localparam int     HALF_W      = REM_W / 2;
    localparam int     RECIP_SHIFT = REM_W + $clog2(DAY_DIV);
    localparam int     RECIP_W     = REM_W + 1;
    localparam logic [RECIP_W-1:0] DAY_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DAY_DIV) - 64'd1) / 64'(DAY_DIV));
    localparam int     PPROD_W     = HALF_W + RECIP_W;
    localparam int     PROD_W      = REM_W + RECIP_W;
    localparam int     DAY_W       = PROD_W - RECIP_SHIFT;
    localparam int     FRONT_STAGES = 2;

    localparam int CMDQ_DEPTH  = 4;
    localparam int RES_DEPTH   = 2;

    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam logic [PADDR_W-3:0] REG_BEAR_DAYS_NEEDED = '0;

    typedef struct packed {
        logic               do_push;
        logic [PRICE_W-1:0] close;
    } t_cmd;

    typedef struct packed {
        logic             bear;
        logic [RUN_W-1:0] bear_days;
        logic             window_full;
    } t_res;

endpackage

[hdl/sbrd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrd_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module sbrd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 200
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/sbrd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrd_front
// accepts items, derives the utc day index and decides which close to push
// ----------------------------------------------------------------------------
module sbrd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic                        i_kind,
    input  logic [sbrd_pkg::TIME_W-1:0] i_time_ms,
    input  logic [sbrd_pkg::PRICE_W-1:0] i_price,
    output logic                        o_cmd_wr,
    output sbrd_pkg::t_cmd              o_cmd,
    input  logic                        i_cmd_full
);
    import sbrd_pkg::*;

    localparam int LAST = FRONT_STAGES - 1;

    logic               r_vld   [FRONT_STAGES];
    logic               r_kind  [FRONT_STAGES];
    logic [PRICE_W-1:0] r_price [FRONT_STAGES];
    logic [PPROD_W-1:0] r_plo;
    logic [PPROD_W-1:0] r_phi;
    logic [DAY_W-1:0]   r_quo;

    logic [REM_W-1:0]   time_k;
    logic [PPROD_W-1:0] n_plo;
    logic [PPROD_W-1:0] n_phi;
    logic [PROD_W-1:0]  prod;

    logic               r_day_started;
    logic [DAY_W-1:0]   r_cur_day;
    logic [PRICE_W-1:0] r_last_price;

    logic               adv;
    logic               fire;
    logic               new_day;

    // day index as a reciprocal product, split into two half-width partial products
    assign time_k = i_time_ms[TIME_W-1:MS_SHIFT];
    assign n_plo  = PPROD_W'(time_k[HALF_W-1:0]) * PPROD_W'(DAY_RECIP);
    assign n_phi  = PPROD_W'(time_k[REM_W-1:HALF_W]) * PPROD_W'(DAY_RECIP);
    assign prod   = (PROD_W'(r_phi) << HALF_W) + PROD_W'(r_plo);

    assign adv    = !(r_vld[LAST] && i_cmd_full);
    assign o_full = !adv;
    assign fire   = adv && r_vld[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FRONT_STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (adv) begin
            r_vld[0] <= i_push;
            for (int k = 1; k < FRONT_STAGES; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_kind[0]  <= i_kind;
            r_price[0] <= i_price;
            r_plo      <= n_plo;
            r_phi      <= n_phi;
            r_quo      <= prod[PROD_W-1:RECIP_SHIFT];
            for (int k = 1; k < FRONT_STAGES; k++) begin
                r_kind[k]  <= r_kind[k-1];
                r_price[k] <= r_price[k-1];
            end
        end
    end

    // classification against the day currently open
    assign new_day       = r_quo != r_cur_day;
    assign o_cmd.do_push = r_kind[LAST] || (r_day_started && new_day);
    assign o_cmd.close   = r_kind[LAST] ? r_price[LAST] : r_last_price;
    assign o_cmd_wr      = fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day_started <= 1'b0;
            r_cur_day     <= '0;
            r_last_price  <= '0;
        end else if (fire && !r_kind[LAST]) begin
            r_day_started <= 1'b1;
            r_cur_day     <= r_quo;
            r_last_price  <= r_price[LAST];
        end
    end

endmodule

[hdl/sbrd_cmdq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrd_cmdq
// short queue of classified transactions between front and back
// ----------------------------------------------------------------------------
module sbrd_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  sbrd_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_rd,
    output sbrd_pkg::t_cmd o_data,
    output logic           o_empty
);
    import sbrd_pkg::*;

    localparam int PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    t_cmd             r_mem [CMDQ_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    logic             do_wr;
    logic             do_rd;

    assign o_full  = r_cnt == CNT_W'(CMDQ_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rp];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= (r_wp == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= (r_rp == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            unique case ({do_wr, do_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

[hdl/sbrd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrd_back
// close ring, running sum, trend test, run counter and result buffer
// ----------------------------------------------------------------------------
module sbrd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sbrd_pkg::t_cmd              i_cmd,
    input  logic                        i_cmd_empty,
    output logic                        o_cmd_pop,
    input  logic [sbrd_pkg::NEED_W-1:0] i_need,
    output sbrd_pkg::t_res              o_res,
    output logic                        o_res_empty,
    input  logic                        i_res_pop
);
    import sbrd_pkg::*;

    localparam int RPTR_W = $clog2(RES_DEPTH);
    localparam int RCNT_W = $clog2(RES_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CALC = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [SEEN_W-1:0]  r_seen, n_seen;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [SUM_W-1:0]   r_prev, n_prev;
    logic [RUN_W-1:0]   r_run, n_run;
    logic               r_flag, n_flag;
    logic [PRICE_W-1:0] r_close, n_close;
    logic [SUM_W-1:0]   r_c200, n_c200;
    logic [SUM_W-1:0]   r_sum_plus, n_sum_plus;

    t_res               r_rbuf [RES_DEPTH];
    logic [RPTR_W-1:0]  r_rwp;
    logic [RPTR_W-1:0]  r_rrp;
    logic [RCNT_W-1:0]  r_rcnt;

    logic               res_room;
    logic               res_wr;
    t_res               res_data;
    logic               res_rd;

    logic               ram_re;
    logic               ram_we;
    logic [PRICE_W-1:0] ram_rdata;

    logic               full_before;
    logic               full_after;
    logic [SUM_W-1:0]   new_sum;
    logic               bearish;

    sbrd_ram #(
        .WIDTH (PRICE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_close),
        .i_re    (ram_re),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    assign res_room    = r_rcnt != RCNT_W'(RES_DEPTH);
    assign full_before = r_seen == SEEN_W'(WINDOW);
    assign full_after  = full_before || (r_seen == SEEN_W'(WINDOW - 1));
    assign new_sum     = r_sum_plus - (full_before ? SUM_W'(ram_rdata) : '0);
    assign bearish     = (r_prev != '0) && (r_c200 < new_sum) && (new_sum < r_prev);

    always_comb begin
        n_state    = r_state;
        n_slot     = r_slot;
        n_seen     = r_seen;
        n_sum      = r_sum;
        n_prev     = r_prev;
        n_run      = r_run;
        n_flag     = r_flag;
        n_close    = r_close;
        n_c200     = r_c200;
        n_sum_plus = r_sum_plus;
        o_cmd_pop  = 1'b0;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        res_wr     = 1'b0;
        res_data   = '{bear: r_flag, bear_days: r_run, window_full: full_before};
        unique case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty && res_room) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.do_push) begin
                        ram_re     = 1'b1;
                        n_close    = i_cmd.close;
                        n_c200     = SUM_W'(i_cmd.close) * SUM_W'(WINDOW);
                        n_sum_plus = r_sum + SUM_W'(i_cmd.close);
                        n_state    = ST_CALC;
                    end else begin
                        res_wr = 1'b1;
                    end
                end
            end
            ST_CALC: begin
                ram_we = 1'b1;
                n_sum  = new_sum;
                n_slot = (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
                if (!full_before) begin
                    n_seen = r_seen + 1'b1;
                end
                if (!full_after) begin
                    n_prev = '0;
                end else begin
                    if (bearish) begin
                        n_run = (r_run == RUN_MAX) ? r_run : r_run + 1'b1;
                    end else begin
                        n_run = '0;
                    end
                    n_flag = n_run >= RUN_W'(i_need);
                    n_prev = new_sum;
                end
                res_wr   = 1'b1;
                res_data = '{bear: n_flag, bear_days: n_run, window_full: full_after};
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_slot  <= '0;
            r_seen  <= '0;
            r_sum   <= '0;
            r_prev  <= '0;
            r_run   <= '0;
            r_flag  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_seen  <= n_seen;
            r_sum   <= n_sum;
            r_prev  <= n_prev;
            r_run   <= n_run;
            r_flag  <= n_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_close    <= n_close;
        r_c200     <= n_c200;
        r_sum_plus <= n_sum_plus;
    end

    // result buffer
    assign o_res_empty = r_rcnt == '0;
    assign o_res       = r_rbuf[r_rrp];
    assign res_rd      = i_res_pop && !o_res_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rwp  <= '0;
            r_rrp  <= '0;
            r_rcnt <= '0;
        end else begin
            if (res_wr) begin
                r_rwp <= (r_rwp == RPTR_W'(RES_DEPTH - 1)) ? '0 : r_rwp + 1'b1;
            end
            if (res_rd) begin
                r_rrp <= (r_rrp == RPTR_W'(RES_DEPTH - 1)) ? '0 : r_rrp + 1'b1;
            end
            unique case ({res_wr, res_rd})
                2'b10:   r_rcnt <= r_rcnt + 1'b1;
                2'b01:   r_rcnt <= r_rcnt - 1'b1;
                default: r_rcnt <= r_rcnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_wr) begin
            r_rbuf[r_rwp] <= res_data;
        end
    end

endmodule

[hdl/sustained_bear_regime_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sustained_bear_regime_detector
// moving-average trend filter over daily closes with a bearish-day run count
// ----------------------------------------------------------------------------
// One item can be pushed every clock cycle while full is low. The front is a
// two-stage pipeline that turns the tick time into a utc day index by
// reciprocal multiplication; from its last stage the item goes into the
// command queue, where the back picks it up. An item that closes a day or
// seeds a close is handled by the back as a ring read, then a sum update and
// trend test on the registered read data, and the back takes no new item
// until it is through; any other item has its result written from idle.
// A four-entry queue between front and back and a two-entry result buffer
// absorb bursts and stalls. The close ring needs no clearing after reset.
module sustained_bear_regime_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_kind,
    input  logic [sbrd_pkg::TIME_W-1:0]   i_time_ms,
    input  logic [sbrd_pkg::PRICE_W-1:0]  i_price,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_bear,
    output logic [sbrd_pkg::RUN_W-1:0]    o_bear_days,
    output logic                          o_window_full,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbrd_pkg::PADDR_W-1:0]  paddr,
    input  logic [sbrd_pkg::PDATA_W-1:0]  pwdata,
    output logic [sbrd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import sbrd_pkg::*;

    logic [NEED_W-1:0] r_need;
    logic              reg_sel;

    logic              cmd_wr;
    t_cmd              cmd_in;
    logic              cmd_full;
    logic              cmd_pop;
    t_cmd              cmd_out;
    logic              cmd_empty;
    t_res              res;

    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1:2] == REG_BEAR_DAYS_NEEDED;
    assign prdata  = reg_sel ? PDATA_W'(r_need) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need <= NEED_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_need <= pwdata[NEED_W-1:0];
        end
    end

    sbrd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_kind     (i_kind),
        .i_time_ms  (i_time_ms),
        .i_price    (i_price),
        .o_cmd_wr   (cmd_wr),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full)
    );

    sbrd_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_wr),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_rd    (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    sbrd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_need      (r_need),
        .o_res       (res),
        .o_res_empty (empty),
        .i_res_pop   (pop)
    );

    assign o_bear        = res.bear;
    assign o_bear_days   = res.bear_days;
    assign o_window_full = res.window_full;

endmodule

[hdl/sbrd_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrd_chk
// port-level checks of the bear regime detector, bound to the top level
// ----------------------------------------------------------------------------
module sbrd_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    input  logic                          full,
    input  logic                          empty,
    input  logic                          pop,
    input  logic                          o_bear,
    input  logic [sbrd_pkg::RUN_W-1:0]    o_bear_days,
    input  logic                          o_window_full
);
    import sbrd_pkg::*;

    logic [7:0] r_open;
    logic       r_seen_full;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = push && !full;
    assign out_acc = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= '0;
            r_seen_full <= 1'b0;
        end else begin
            r_open <= r_open + 8'(in_acc) - 8'(out_acc);
            if (out_acc && o_window_full) begin
                r_seen_full <= 1'b1;
            end
        end
    end

    // every shown result belongs to an accepted transaction
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> r_open != '0)
        else $error("result shown with no transaction outstanding");

    // a full window never empties again
    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && r_seen_full) |-> o_window_full)
        else $error("window_full dropped after being reported");

    // a bearish run can only exist once the window is full
    a_run_needs_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_bear_days == '0 || o_window_full))
        else $error("bear run reported before the window filled");

    // a waiting result stays until it is taken
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_bear_days) && $stable(o_bear)))
        else $error("stalled result changed or vanished");

endmodule

bind sustained_bear_regime_detector sbrd_chk u_chk (.*);

[verif/tb_sustained_bear_regime_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sustained_bear_regime_detector
// self-checking testbench for the sustained bear regime detector
// ----------------------------------------------------------------------------
// Price ticks and seeding closes go in on the push/full side. Results are
// popped under random back-pressure. Every result is compared with a
// cycle-free model of the moving-average trend filter. That model lives in a
// small scoreboard class. Traffic fills the window first, then runs as a mix
// of falling and rising close sequences, same-day tick chatter and random
// noise. Between phases the threshold register is rewritten and read back
// over the apb port, and the sender and receiver idling pattern is changed.
// ----------------------------------------------------------------------------
module tb_sustained_bear_regime_detector;
    import sbrd_pkg::*;

    localparam longint unsigned DAY_MS   = 64'd86_400_000;
    localparam int unsigned     LAST_DAY = 203_000;
    localparam int              N_ITEMS  = 1400;
    localparam int              N_SEGS   = 7;
    localparam logic [PADDR_W-1:0] NEED_ADDR = {REG_BEAR_DAYS_NEEDED, 2'b00};

    class bear_scoreboard;
        logic [PRICE_W-1:0] ring [WINDOW];
        int unsigned        slot     = 0;
        int unsigned        seen     = 0;
        logic [SUM_W-1:0]   sum      = '0;
        logic [SUM_W-1:0]   prev_sum = '0;
        logic [RUN_W-1:0]   run      = '0;
        bit                 flag     = 1'b0;
        bit                 day_open = 1'b0;
        logic [23:0]        today    = '0;
        logic [PRICE_W-1:0] kept     = '0;
        logic [NEED_W-1:0]  need     = NEED_RESET;
        t_res               pending [$];
        int                 errors   = 0;

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void add_close(logic [PRICE_W-1:0] c);
            logic [47:0] scaled;
            if (seen >= WINDOW) sum = sum - SUM_W'(ring[slot]);
            ring[slot] = c;
            sum = sum + SUM_W'(c);
            slot = (slot + 1) % WINDOW;
            if (seen < WINDOW) seen++;
            if (seen < WINDOW) begin
                prev_sum = '0;
                return;
            end
            scaled = 48'(c) * 48'(WINDOW);
            if (prev_sum != 0 && scaled < 48'(sum) && sum < prev_sum) begin
                if (run != RUN_MAX) run++;
            end else begin
                run = '0;
            end
            flag = (run >= 16'(need));
            prev_sum = sum;
        endfunction

        function void note_input(logic kind, logic [TIME_W-1:0] t, logic [PRICE_W-1:0] px);
            logic [23:0] day;
            t_res        r;
            day = 24'(64'(t) / DAY_MS);
            if (kind) begin
                add_close(px);
            end else begin
                if (!day_open) begin
                    day_open = 1'b1;
                    today = day;
                end else if (day != today) begin
                    add_close(kept);
                    today = day;
                end
                kept = px;
            end
            r.bear        = flag;
            r.bear_days   = run;
            r.window_full = (seen >= WINDOW);
            pending = {pending, r};
        endfunction

        task check_result(logic bear, logic [RUN_W-1:0] days, logic wfull);
            t_res e;
            if (pending.size() == 0) begin
                report($sformatf("result with none outstanding (bear %0b days %0d)",
                                 bear, days));
                return;
            end
            e = pending[0];
            pending.delete(0);
            if (bear !== e.bear)
                report($sformatf("bear got %0b want %0b", bear, e.bear));
            if (days !== e.bear_days)
                report($sformatf("bear_days got %0d want %0d", days, e.bear_days));
            if (wfull !== e.window_full)
                report($sformatf("window_full got %0b want %0b", wfull, e.window_full));
        endtask
    endclass

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               push      = 1'b0;
    logic               full;
    logic               i_kind    = 1'b0;
    logic [TIME_W-1:0]  i_time_ms = '0;
    logic [PRICE_W-1:0] i_price   = '0;
    logic               empty;
    logic               pop       = 1'b0;
    logic               o_bear;
    logic [RUN_W-1:0]   o_bear_days;
    logic               o_window_full;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int          send_idle  = 0;
    int          recv_stall = 0;
    int          n_sent     = 0;
    int unsigned day_cursor = 1000;

    bear_scoreboard sb = new;

    sustained_bear_regime_detector u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_kind        (i_kind),
        .i_time_ms     (i_time_ms),
        .i_price       (i_price),
        .empty         (empty),
        .pop           (pop),
        .o_bear        (o_bear),
        .o_bear_days   (o_bear_days),
        .o_window_full (o_window_full),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_stall);
    end

    // transaction monitor on both sides
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) sb.check_result(o_bear, o_bear_days, o_window_full);
            if (push && !full) sb.note_input(i_kind, i_time_ms, i_price);
        end
    end

    function automatic logic [TIME_W-1:0] rand_time();
        return TIME_W'({$urandom, $urandom});
    endfunction

    function automatic logic [TIME_W-1:0] tick_time(int unsigned day);
        return TIME_W'(64'(day) * DAY_MS + 64'($urandom_range(32'd86_399_999)));
    endfunction

    function automatic void next_day();
        day_cursor += $urandom_range(1, 3);
        if (day_cursor > LAST_DAY) day_cursor = $urandom_range(1000);
    endfunction

    task automatic send_item(input logic kind, input logic [TIME_W-1:0] t,
                             input logic [PRICE_W-1:0] px);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_kind    <= kind;
        i_time_ms <= t;
        i_price   <= px;
        do @(posedge i_clk); while (full);
        n_sent++;
    endtask

    // a close either seeded directly or as the last tick of a day
    task automatic emit_close(input bit by_tick, input logic [PRICE_W-1:0] p);
        if (!by_tick) begin
            send_item(1'b1, rand_time(), p);
        end else begin
            repeat ($urandom_range(2)) send_item(1'b0, tick_time(day_cursor), $urandom);
            send_item(1'b0, tick_time(day_cursor), p);
            next_day();
        end
    endtask

    task automatic trend_run(input bit falling, input int len);
        longint unsigned lvl;
        longint unsigned stepv;
        bit              by_tick;
        by_tick = 1'($urandom_range(1));
        lvl = sb.sum / WINDOW;
        if (falling) lvl = lvl - (lvl >> $urandom_range(2, 6));
        else lvl = lvl + (lvl >> 3) + $urandom_range(1, 5000);
        stepv = (lvl >> $urandom_range(6, 10)) + 1;
        repeat (len) begin
            if (lvl > 64'hFFFF_FFFF) lvl = 64'hFFFF_FFFF;
            emit_close(by_tick, lvl[31:0]);
            if (falling) begin
                if (lvl > stepv * 3) lvl = lvl - stepv * $urandom_range(1, 3);
            end else begin
                lvl = lvl + stepv * $urandom_range(0, 3);
            end
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [PDATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input logic [PADDR_W-1:0] a, output logic [PDATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= a;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        d = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_threshold(input logic [NEED_W-1:0] v);
        logic [PDATA_W-1:0] rd;
        apb_write(NEED_ADDR, PDATA_W'(v));
        sb.need = v;
        apb_read(NEED_ADDR, rd);
        if (rd[NEED_W-1:0] !== v)
            sb.report($sformatf("threshold read %0d want %0d", rd[NEED_W-1:0], v));
    endtask

    initial begin
        #(4_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [PDATA_W-1:0] rd;
        logic [NEED_W-1:0]  thr;
        int                 seg_end;
        int                 r;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_read(NEED_ADDR, rd);
        if (rd[NEED_W-1:0] !== NEED_RESET)
            sb.report($sformatf("threshold after reset %0d", rd[NEED_W-1:0]));

        // first tick, zero price, day change, going back a day, seeding extremes
        send_item(1'b0, '0, '1);
        send_item(1'b0, TIME_W'(DAY_MS - 1), '0);
        send_item(1'b0, '1, 32'h0000_0001);
        send_item(1'b0, TIME_W'(DAY_MS * 5), 32'hFFFF_FFFF);
        send_item(1'b1, '1, '1);
        send_item(1'b1, '0, '0);
        send_item(1'b0, TIME_W'(DAY_MS * 5 + 7), 32'h8000_0000);
        send_item(1'b0, TIME_W'(DAY_MS * 6), 32'h7FFF_FFFF);
        send_item(1'b1, 44'h555_5555_5555, 32'hAAAA_AAAA);
        send_item(1'b1, 44'hAAA_AAAA_AAAA, 32'h5555_5555);

        // window filling, previous sum held at zero until the window is full
        repeat (WINDOW) emit_close($urandom_range(3) == 0, $urandom);

        for (int seg = 0; seg < N_SEGS; seg++) begin
            drain();
            case (seg)
                0: thr = 10'd1;
                1: thr = 10'd0;
                2: thr = 10'd1023;
                3: thr = 10'd3;
                4: thr = NEED_W'($urandom_range(2, 40));
                5: thr = 10'd20;
                default: thr = NEED_W'($urandom_range(1, 1023));
            endcase
            set_threshold(thr);
            case (seg % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 56; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 56; end
                default: begin send_idle = 8; recv_stall = 8; end
            endcase
            seg_end = n_sent + (N_ITEMS - n_sent) / (N_SEGS - seg);
            while (n_sent < seg_end) begin
                r = $urandom_range(99);
                if (r < 45) begin
                    trend_run(1'b1, $urandom_range(4, 40));
                end else if (r < 70) begin
                    trend_run(1'b0, $urandom_range(2, 15));
                end else if (r < 88) begin
                    repeat ($urandom_range(2, 6))
                        send_item(1'b0, tick_time(day_cursor), $urandom);
                    next_day();
                end else begin
                    repeat ($urandom_range(1, 5))
                        send_item(1'($urandom_range(1)), rand_time(), $urandom);
                end
            end
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
hdl/sbrd_pkg.sv
hdl/sbrd_ram.sv
hdl/sbrd_front.sv
hdl/sbrd_cmdq.sv
hdl/sbrd_back.sv
hdl/sustained_bear_regime_detector.sv
hdl/sbrd_chk.sv
verif/tb_sustained_bear_regime_detector.sv
